@@ rtl/pixel_matrix_config_serializer_unit_macros.svh @@
// Assertion macros used by the serializer top level.
`ifndef PIXEL_MATRIX_CONFIG_SERIALIZER_UNIT_MACROS_SVH
`define PIXEL_MATRIX_CONFIG_SERIALIZER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define PMCS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define PMCS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/pmcs_pkg.sv @@
// Constants, types and helper functions of the pixel matrix serializer.
`timescale 1ns / 1ps
`default_nettype none
package pmcs_pkg;

	localparam int MATRIX_SIDE     = 256;
	localparam int PLANES_PER_ROW  = 14;
	localparam int POSTLOAD_BYTES  = 32;
	localparam int PLANE_BYTES     = MATRIX_SIDE / 8;
	localparam int ROW_BYTES       = PLANE_BYTES * PLANES_PER_ROW;
	localparam int DATA_BYTES      = ROW_BYTES * MATRIX_SIDE;
	localparam int CHIP_STRIDE     = DATA_BYTES + POSTLOAD_BYTES;

	localparam int INDEX_W         = 20;
	localparam int CHIP_W          = 3;
	localparam int COORD_W         = 8;
	localparam int THR_W           = 4;
	localparam int NUM_CHIPS_W     = 4;
	localparam int BYTE_W          = 8;

	localparam int CHIP_SLOTS      = ((1 << INDEX_W) - 2) / CHIP_STRIDE + 1;
	localparam int SLOT_W          = $clog2(CHIP_SLOTS);
	localparam int OFF_W           = $clog2(CHIP_STRIDE);

	// Row split: ROW_BYTES = ROW_GRP_DIV << ROW_GRP_SHIFT
	localparam int ROW_GRP_SHIFT   = 6;
	localparam int ROW_GRP_DIV     = ROW_BYTES >> ROW_GRP_SHIFT;
	localparam int RECIP_SHIFT     = 16;
	localparam int RECIP           = (1 << RECIP_SHIFT) / ROW_GRP_DIV + 1;
	localparam int RECIP_W         = $clog2(RECIP + 1);
	localparam int GRP_W           = OFF_W - ROW_GRP_SHIFT;
	localparam int REM_W           = $clog2(ROW_GRP_DIV);

	localparam int PIX_PER_WORD    = 8;
	localparam int WORD_BITS       = PIX_PER_WORD * 8;
	localparam int LANE_W          = $clog2(PIX_PER_WORD);
	localparam int WORDS_PER_ROW   = MATRIX_SIDE / PIX_PER_WORD;
	localparam int WSEL_W          = $clog2(WORDS_PER_ROW);
	localparam int MAX_ADDR_W      = CHIP_W + COORD_W + WSEL_W;
	localparam int PLANE_W         = REM_W + 1;
	localparam int DATA_PLANES     = 8;

	localparam logic [BYTE_W-1:0] FILL_BYTE = 8'hFF;

	typedef struct packed {
		logic                    en;
		logic [MAX_ADDR_W-1:0]   addr;
		logic [LANE_W-1:0]       lane;
		logic [BYTE_W-1:0]       data;
	} wr_req_t;

	typedef struct packed {
		logic                    en;
		logic [MAX_ADDR_W-1:0]   addr;
	} rd_req_t;

	function automatic logic [2:0] plane_word_bit(input logic [2:0] plane);
		logic [2:0] bit_sel;
		case (plane)
			3'd0:    bit_sel = 3'd7;
			3'd1:    bit_sel = 3'd1;
			3'd2:    bit_sel = 3'd3;
			3'd3:    bit_sel = 3'd2;
			3'd4:    bit_sel = 3'd4;
			3'd5:    bit_sel = 3'd0;
			3'd6:    bit_sel = 3'd6;
			3'd7:    bit_sel = 3'd5;
			default: bit_sel = 3'd0;
		endcase
		return bit_sel;
	endfunction

endpackage
`default_nettype wire

@@ rtl/pmcs_req_if.sv @@
// Request channel: pixel writes and stream byte reads.
`timescale 1ns / 1ps
`default_nettype none
interface pmcs_req_if;
	logic                               valid;
	logic                               ready;
	logic                               req_type;
	logic [pmcs_pkg::CHIP_W-1:0]        chip_index;
	logic [pmcs_pkg::COORD_W-1:0]       pixel_row;
	logic [pmcs_pkg::COORD_W-1:0]       pixel_column;
	logic [pmcs_pkg::THR_W-1:0]         threshold_adjust;
	logic                               mode_bit_zero;
	logic                               mode_bit_one;
	logic                               mask_bit;
	logic                               test_bit;
	logic [pmcs_pkg::INDEX_W-1:0]       byte_index;

	modport source (
		output valid, req_type, chip_index, pixel_row, pixel_column, threshold_adjust,
		       mode_bit_zero, mode_bit_one, mask_bit, test_bit, byte_index,
		input  ready
	);
	modport sink (
		input  valid, req_type, chip_index, pixel_row, pixel_column, threshold_adjust,
		       mode_bit_zero, mode_bit_one, mask_bit, test_bit, byte_index,
		output ready
	);
endinterface
`default_nettype wire

@@ rtl/pmcs_rsp_if.sv @@
// Response channel: one stream byte per read.
`timescale 1ns / 1ps
`default_nettype none
interface pmcs_rsp_if;
	logic                           valid;
	logic                           ready;
	logic [pmcs_pkg::BYTE_W-1:0]    stream_byte;
	logic                           beyond_end;

	modport source (
		output valid, stream_byte, beyond_end,
		input  ready
	);
	modport sink (
		input  valid, stream_byte, beyond_end,
		output ready
	);
endinterface
`default_nettype wire

@@ rtl/pmcs_store.sv @@
// Pixel word store: eight pixels per word, byte-lane writes, registered read.
`timescale 1ns / 1ps
`default_nettype none
module pmcs_store #(
	parameter int MAX_CHIPS = 8
) (
	input  wire logic                                clk,
	input  wire pmcs_pkg::wr_req_t                   wr,
	input  wire pmcs_pkg::rd_req_t                   rd,
	output logic [pmcs_pkg::WORD_BITS-1:0]           rdata
);
	localparam int DEPTH  = MAX_CHIPS * pmcs_pkg::MATRIX_SIDE * pmcs_pkg::WORDS_PER_ROW;
	localparam int ADDR_W = $clog2(DEPTH);

	logic [pmcs_pkg::WORD_BITS-1:0] mem [DEPTH];
	logic [pmcs_pkg::WORD_BITS-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr[ADDR_W-1:0]][{wr.lane, 3'b000} +: pmcs_pkg::BYTE_W] <= wr.data;
		end
		if (rd.en) begin
			rdata_q <= mem[rd.addr[ADDR_W-1:0]];
		end
	end

	assign rdata = rdata_q;
endmodule
`default_nettype wire

@@ rtl/pixel_matrix_config_serializer_unit.sv @@
// Top level of the pixel matrix configuration serializer.
// A read beat passes stages 1 to 4 and the output register before its byte shows on rsp.
// Throughput: one request beat per cycle while rsp does not stall; the single read port of the store sets it.
// Writes pass stages 1 to 3 and land in the store from stage 3, in order with reads.
// Reset clears the pipeline and output valids and sets num_chips to 1.
// Store contents are undefined after reset until written; there is no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
`include "pixel_matrix_config_serializer_unit_macros.svh"
module pixel_matrix_config_serializer_unit #(
	parameter int MAX_CHIPS = 8
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  cfg_wr_en,
	input  wire logic [pmcs_pkg::NUM_CHIPS_W-1:0]      cfg_wr_data,
	pmcs_req_if.sink                                   req,
	pmcs_rsp_if.source                                 rsp
);
	localparam int NC_W = pmcs_pkg::NUM_CHIPS_W;

	logic [NC_W-1:0] num_chips_q;
	logic [NC_W-1:0] chips_used;

	// pipeline control
	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic rd_s1, rd_s2, rd_s3;
	logic rdy1, rdy2, rdy3, rdy4, out_en;

	// read path
	logic                              preload_s1, preload_s2, preload_s3, preload_s4;
	logic [pmcs_pkg::SLOT_W-1:0]       chip_d, chip_s1, chip_s2, chip_s3;
	logic [pmcs_pkg::INDEX_W-1:0]      j_s1;
	logic [pmcs_pkg::INDEX_W-1:0]      base_d;
	logic [pmcs_pkg::OFF_W-1:0]        off_s2;
	logic                              beyond_s2, beyond_s3, beyond_s4;
	logic                              fill_s3, fill_s4;
	logic [pmcs_pkg::GRP_W-1:0]        grp_d, grp_s3;
	logic [pmcs_pkg::GRP_W+pmcs_pkg::RECIP_W-1:0] prod_d;
	logic [pmcs_pkg::COORD_W-1:0]      row_s3;
	logic [pmcs_pkg::ROW_GRP_SHIFT-1:0] sub_s3;
	logic [pmcs_pkg::REM_W-1:0]        rem_d;
	logic [pmcs_pkg::PLANE_W-1:0]      plane_d, plane_s4;
	logic                              need_mem;

	// write path
	logic                              wok_s1, wok_s2, wok_s3;
	logic [pmcs_pkg::MAX_ADDR_W-1:0]   waddr_s1, waddr_s2, waddr_s3;
	logic [pmcs_pkg::LANE_W-1:0]       lane_s1, lane_s2, lane_s3;
	logic [pmcs_pkg::BYTE_W-1:0]       wdata_s1, wdata_s2, wdata_s3;

	pmcs_pkg::wr_req_t                 wr;
	pmcs_pkg::rd_req_t                 rd;
	logic [pmcs_pkg::WORD_BITS-1:0]    rdata;

	// output register
	logic                              out_valid_q;
	logic [pmcs_pkg::BYTE_W-1:0]       out_byte_q;
	logic                              out_beyond_q;
	logic [pmcs_pkg::BYTE_W-1:0]       byte_d;
	logic [2:0]                        wbit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_chips_q <= NC_W'(1);
		end else if (cfg_wr_en) begin
			num_chips_q <= cfg_wr_data;
		end
	end

	always_comb begin
		if (num_chips_q == '0) begin
			chips_used = NC_W'(1);
		end else if (num_chips_q > NC_W'(MAX_CHIPS)) begin
			chips_used = NC_W'(MAX_CHIPS);
		end else begin
			chips_used = num_chips_q;
		end
	end

	// stall chain; writes leave stage 3 without waiting
	assign out_en    = !out_valid_q || rsp.ready;
	assign rdy4      = !valid_s4 || out_en;
	assign rdy3      = !valid_s3 || !rd_s3 || rdy4;
	assign rdy2      = !valid_s2 || rdy3;
	assign rdy1      = !valid_s1 || rdy2;
	assign req.ready = rdy1;

	always_comb begin
		chip_d = '0;
		for (int k = 1; k < pmcs_pkg::CHIP_SLOTS; k++) begin
			if (req.byte_index >= pmcs_pkg::INDEX_W'(k * pmcs_pkg::CHIP_STRIDE + 1)) begin
				chip_d = pmcs_pkg::SLOT_W'(k);
			end
		end
	end

	always_comb begin
		base_d = '0;
		for (int k = 0; k < pmcs_pkg::CHIP_SLOTS; k++) begin
			if (chip_s1 == pmcs_pkg::SLOT_W'(k)) begin
				base_d = pmcs_pkg::INDEX_W'(k * pmcs_pkg::CHIP_STRIDE);
			end
		end
	end

	assign grp_d  = off_s2[pmcs_pkg::OFF_W-1:pmcs_pkg::ROW_GRP_SHIFT];
	assign prod_d = (pmcs_pkg::GRP_W + pmcs_pkg::RECIP_W)'(grp_d)
	              * (pmcs_pkg::GRP_W + pmcs_pkg::RECIP_W)'(pmcs_pkg::RECIP);

	assign rem_d    = pmcs_pkg::REM_W'(grp_s3
	                - pmcs_pkg::GRP_W'(pmcs_pkg::ROW_GRP_DIV) * pmcs_pkg::GRP_W'(row_s3));
	assign plane_d  = {rem_d, sub_s3[pmcs_pkg::WSEL_W]};
	assign need_mem = !preload_s3 && !beyond_s3 && !fill_s3
	               && (plane_d < pmcs_pkg::PLANE_W'(pmcs_pkg::DATA_PLANES));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (rdy1) valid_s1 <= req.valid;
			if (rdy2) valid_s2 <= valid_s1;
			if (rdy3) valid_s3 <= valid_s2;
			if (rdy4) valid_s4 <= valid_s3 && rd_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1) begin
			rd_s1      <= req.req_type;
			preload_s1 <= req.byte_index == '0;
			chip_s1    <= chip_d;
			j_s1       <= req.byte_index - pmcs_pkg::INDEX_W'(1);
			wok_s1     <= {1'b0, req.chip_index} < (pmcs_pkg::CHIP_W + 1)'(MAX_CHIPS);
			waddr_s1   <= {req.chip_index, req.pixel_row,
			               req.pixel_column[pmcs_pkg::COORD_W-1:pmcs_pkg::LANE_W]};
			lane_s1    <= req.pixel_column[pmcs_pkg::LANE_W-1:0];
			wdata_s1   <= {req.test_bit, req.mask_bit, req.mode_bit_one, req.mode_bit_zero,
			               req.threshold_adjust};
		end
		if (rdy2) begin
			rd_s2      <= rd_s1;
			preload_s2 <= preload_s1;
			chip_s2    <= chip_s1;
			off_s2     <= pmcs_pkg::OFF_W'(j_s1 - base_d);
			beyond_s2  <= !preload_s1 && ({1'b0, chip_s1} >= (pmcs_pkg::SLOT_W + 1)'(chips_used));
			wok_s2     <= wok_s1;
			waddr_s2   <= waddr_s1;
			lane_s2    <= lane_s1;
			wdata_s2   <= wdata_s1;
		end
		if (rdy3) begin
			rd_s3      <= rd_s2;
			preload_s3 <= preload_s2;
			chip_s3    <= chip_s2;
			beyond_s3  <= beyond_s2;
			fill_s3    <= off_s2 >= pmcs_pkg::OFF_W'(pmcs_pkg::DATA_BYTES);
			grp_s3     <= grp_d;
			row_s3     <= prod_d[pmcs_pkg::RECIP_SHIFT +: pmcs_pkg::COORD_W];
			sub_s3     <= off_s2[pmcs_pkg::ROW_GRP_SHIFT-1:0];
			wok_s3     <= wok_s2;
			waddr_s3   <= waddr_s2;
			lane_s3    <= lane_s2;
			wdata_s3   <= wdata_s2;
		end
		if (rdy4) begin
			preload_s4 <= preload_s3;
			beyond_s4  <= beyond_s3;
			fill_s4    <= fill_s3;
			plane_s4   <= plane_d;
		end
	end

	always_comb begin
		wr.en   = valid_s3 && !rd_s3 && wok_s3;
		wr.addr = waddr_s3;
		wr.lane = lane_s3;
		wr.data = wdata_s3;
		rd.en   = valid_s3 && rd_s3 && rdy4 && need_mem;
		rd.addr = {chip_s3[pmcs_pkg::CHIP_W-1:0], row_s3, ~sub_s3[pmcs_pkg::WSEL_W-1:0]};
	end

	pmcs_store #(
		.MAX_CHIPS (MAX_CHIPS)
	) u_store (
		.clk   (clk),
		.wr    (wr),
		.rd    (rd),
		.rdata (rdata)
	);

	assign wbit = pmcs_pkg::plane_word_bit(plane_s4[2:0]);

	always_comb begin
		byte_d = '0;
		if (beyond_s4) begin
			byte_d = '0;
		end else if (preload_s4 || fill_s4) begin
			byte_d = pmcs_pkg::FILL_BYTE;
		end else if (plane_s4 < pmcs_pkg::PLANE_W'(pmcs_pkg::DATA_PLANES)) begin
			for (int i = 0; i < pmcs_pkg::PIX_PER_WORD; i++) begin
				byte_d[i] = rdata[i * 8 + int'(wbit)];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_en) begin
			out_valid_q <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (out_en && valid_s4) begin
			out_byte_q   <= byte_d;
			out_beyond_q <= beyond_s4;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.stream_byte = out_byte_q;
	assign rsp.beyond_end  = out_beyond_q;

	`PMCS_ASSERT_IMP(a_beyond_zero, clk, arst_n, out_valid_q && out_beyond_q, out_byte_q == '0, "beyond-end beat carries nonzero byte")
	`PMCS_ASSERT_IMP(a_rd_owner, clk, arst_n, rd.en, valid_s3 && rd_s3 && !wr.en, "store read without a read in stage 3")
	`PMCS_ASSERT_NXT(a_accept_s1, clk, arst_n, req.valid && req.ready, valid_s1, "accepted beat missing in stage 1")
	`PMCS_ASSERT_IMP(a_out_source, clk, arst_n, !$past(out_valid_q) && out_valid_q, $past(valid_s4), "output valid without stage 4 item")
endmodule
`default_nettype wire
